FILE: rtl/lag_pkg.sv
// ----------------------------------------------------------------------------
// lag_pkg
// shared widths, codes and types for the auto-gain ppfd integrator
// ----------------------------------------------------------------------------
package lag_pkg;

  localparam int COUNT_W    = 16;
  localparam int NUM_COUNTS = 8;
  localparam int SUM_W      = 19;
  localparam int THR_W      = 16;
  localparam int SCALE_W    = 20;
  localparam int GAIN_W     = 4;
  localparam int STEP_W     = 3;
  localparam int ELAPSED_W  = 16;
  localparam int PPFD_W     = 32;
  localparam int PROD1_W    = SUM_W + SCALE_W;
  localparam int PROD2_W    = PPFD_W + ELAPSED_W;
  localparam int TOTAL_W    = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [GAIN_W-1:0] GAIN_TOP   = 4'd10;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CEIL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_STEP = 3'd4;

  typedef enum logic [1:0] {
    ACT_GAIN_CHANGED = 2'd0,
    ACT_ACCEPTED     = 2'd1,
    ACT_UNSTABLE     = 2'd2,
    ACT_CLEARED      = 2'd3
  } action_t;

  typedef logic [NUM_COUNTS-1:0][COUNT_W-1:0] count_arr_t;

endpackage

FILE: rtl/lag_scan.sv
// ----------------------------------------------------------------------------
// lag_scan
// channel scan: counts shift past one compare and one add, one channel a cycle
// ----------------------------------------------------------------------------
module lag_scan #(
  parameter int CHANNELS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  lag_pkg::count_arr_t        counts,
  output logic                       done,
  output logic [lag_pkg::COUNT_W-1:0] max_count,
  output logic [lag_pkg::SUM_W-1:0]  sum
);
  import lag_pkg::*;

  localparam int CNT_W = $clog2(CHANNELS + 1);

  count_arr_t         shreg_r, shreg_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [COUNT_W-1:0] max_r, max_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;

  always_comb begin
    shreg_nxt = shreg_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    max_nxt   = max_r;
    sum_nxt   = sum_r;
    if (start) begin
      shreg_nxt = counts;
      cnt_nxt   = CNT_W'(CHANNELS);
      busy_nxt  = 1'b1;
      max_nxt   = '0;
      sum_nxt   = '0;
    end else if (busy_r) begin
      // head channel into max and sum, the rest move down one place
      if (shreg_r[0] > max_r) begin
        max_nxt = shreg_r[0];
      end
      sum_nxt = sum_r + SUM_W'(shreg_r[0]);
      for (int i = 0; i < NUM_COUNTS - 1; i++) begin
        shreg_nxt[i] = shreg_r[i+1];
      end
      shreg_nxt[NUM_COUNTS-1] = '0;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    shreg_r <= shreg_nxt;
    cnt_r   <= cnt_nxt;
    max_r   <= max_nxt;
    sum_r   <= sum_nxt;
  end

  assign done      = done_r;
  assign max_count = max_r;
  assign sum       = sum_r;

endmodule

FILE: rtl/lag_sermul.sv
// ----------------------------------------------------------------------------
// lag_sermul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module lag_sermul #(
  parameter int WA = 20,
  parameter int WB = 19
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic             done,
  output logic [WA+WB-1:0] p
);

  localparam int CNT_W = $clog2(WB + 1);

  logic [WA-1:0]    a_r, a_nxt;
  logic [WA-1:0]    hi_r, hi_nxt;
  logic [WB-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [WA:0]      part;

  always_comb begin
    a_nxt    = a_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    part     = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
    if (start) begin
      a_nxt    = a;
      hi_nxt   = '0;
      lo_nxt   = b;
      cnt_nxt  = CNT_W'(WB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // partial sum shifts right, low bit drops into the multiplier register
      hi_nxt  = part[WA:1];
      lo_nxt  = {part[0], lo_r[WB-1:1]};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign p    = {hi_r, lo_r};

endmodule

FILE: rtl/light_autogain_ppfd_integrator.sv
// ----------------------------------------------------------------------------
// light_autogain_ppfd_integrator
// auto-gain control with ppfd computation and saturating daily light total
// ----------------------------------------------------------------------------
// throughput: one transaction at a time; the channel scan (one channel a cycle)
//   and two bit-serial multipliers (19 and 16 steps) make up a processed reading
// reset: synchronous active-low rst_n; gain 7, total and ppfd 0, config regs
//   to their defaults, no result pending
// ----------------------------------------------------------------------------
module light_autogain_ppfd_integrator #(
  parameter int MAX_ATTEMPTS = 3,
  parameter int CHANNELS     = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [lag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lag_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [lag_pkg::COUNT_W-1:0]    in_count_f1,
  input  logic [lag_pkg::COUNT_W-1:0]    in_count_f2,
  input  logic [lag_pkg::COUNT_W-1:0]    in_count_f3,
  input  logic [lag_pkg::COUNT_W-1:0]    in_count_f4,
  input  logic [lag_pkg::COUNT_W-1:0]    in_count_f5,
  input  logic [lag_pkg::COUNT_W-1:0]    in_count_f6,
  input  logic [lag_pkg::COUNT_W-1:0]    in_count_f7,
  input  logic [lag_pkg::COUNT_W-1:0]    in_count_f8,
  input  logic [lag_pkg::ELAPSED_W-1:0]  in_elapsed_seconds,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_action,
  output logic [lag_pkg::GAIN_W-1:0]     out_gain_index,
  output logic [lag_pkg::COUNT_W-1:0]    out_max_count,
  output logic [lag_pkg::PPFD_W-1:0]     out_ppfd_q8,
  output logic [lag_pkg::TOTAL_W-1:0]    out_daily_total_umol
);
  import lag_pkg::*;

  localparam int ATT_W = $clog2(MAX_ATTEMPTS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MUL1,
    ST_ROUND,
    ST_KICK2,
    ST_MUL2,
    ST_ACCUM,
    ST_DONE
  } state_t;

  // configuration registers
  logic [THR_W-1:0]   high_thr_r;
  logic [THR_W-1:0]   low_thr_r;
  logic [SCALE_W-1:0] scale_r;
  logic [GAIN_W-1:0]  gain_ceil_r;
  logic [STEP_W-1:0]  gain_step_r;

  // block state
  state_t               state_r;
  logic [GAIN_W-1:0]    gain_r;
  logic [ATT_W-1:0]     attempts_r;
  logic [PPFD_W-1:0]    ppfd_r;
  logic [TOTAL_W-1:0]   total_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  action_t              res_action_r;
  logic [COUNT_W-1:0]   res_max_r;

  // output register
  logic                 out_valid_r;
  logic [1:0]           out_action_r;
  logic [GAIN_W-1:0]    out_gain_r;
  logic [COUNT_W-1:0]   out_max_r;
  logic [PPFD_W-1:0]    out_ppfd_r;
  logic [TOTAL_W-1:0]   out_total_r;

  // datapath units
  count_arr_t           counts;
  logic                 scan_start, scan_done;
  logic [COUNT_W-1:0]   scan_max;
  logic [SUM_W-1:0]     scan_sum;
  logic                 mul1_start, mul1_done;
  logic [PROD1_W-1:0]   prod1;
  logic                 mul2_start, mul2_done;
  logic [PROD2_W-1:0]   prod2;

  // decision and arithmetic
  logic                 in_acc;
  logic [GAIN_W-1:0]    ceil_eff, step_eff, gain_clamp;
  logic [GAIN_W-1:0]    gain_lowered, gain_raised;
  logic [GAIN_W:0]      raise_sum;
  logic                 unstable, is_high, go_down, go_up, gain_change;
  logic [4:0]           shamt;
  logic [PROD1_W:0]     rnd_sum, rnd_shift;
  logic [PPFD_W-1:0]    ppfd_sat;
  logic [PROD2_W:0]     inc_full;
  logic [TOTAL_W:0]     tot_sum;
  logic [TOTAL_W-1:0]   tot_sat;
  logic                 out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign counts[0] = in_count_f1;
  assign counts[1] = in_count_f2;
  assign counts[2] = in_count_f3;
  assign counts[3] = in_count_f4;
  assign counts[4] = in_count_f5;
  assign counts[5] = in_count_f6;
  assign counts[6] = in_count_f7;
  assign counts[7] = in_count_f8;

  // configuration writes, taken only while idle by contract on the user; the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r  <= 16'd17500;
      low_thr_r   <= 16'd1500;
      scale_r     <= 20'd6941;
      gain_ceil_r <= 4'd7;
      gain_step_r <= 3'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HIGH_THR:  high_thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_LOW_THR:   low_thr_r   <= cfg_wdata[THR_W-1:0];
        CFG_SCALE:     scale_r     <= cfg_wdata[SCALE_W-1:0];
        CFG_GAIN_CEIL: gain_ceil_r <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_STEP: gain_step_r <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // max and sum over the channels
  lag_scan #(
    .CHANNELS(CHANNELS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .counts   (counts),
    .done     (scan_done),
    .max_count(scan_max),
    .sum      (scan_sum)
  );

  // channel sum times scale
  lag_sermul #(
    .WA(SCALE_W),
    .WB(SUM_W)
  ) u_mul_ppfd (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul1_start),
    .a    (scale_r),
    .b    (scan_sum),
    .done (mul1_done),
    .p    (prod1)
  );

  // ppfd times elapsed seconds
  lag_sermul #(
    .WA(PPFD_W),
    .WB(ELAPSED_W)
  ) u_mul_dose (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul2_start),
    .a    (ppfd_r),
    .b    (elapsed_r),
    .done (mul2_done),
    .p    (prod2)
  );

  // gain decision, evaluated on the scan results
  always_comb begin
    ceil_eff     = (gain_ceil_r > GAIN_TOP) ? GAIN_TOP : gain_ceil_r;
    // a step of zero behaves as one
    step_eff     = (gain_step_r == '0) ? GAIN_W'(1) : GAIN_W'(gain_step_r);
    unstable     = (attempts_r >= ATT_W'(MAX_ATTEMPTS));
    is_high      = (scan_max >= high_thr_r);
    gain_lowered = (gain_r > step_eff) ? (gain_r - step_eff) : '0;
    raise_sum    = {1'b0, gain_r} + {1'b0, step_eff};
    gain_raised  = (raise_sum > {1'b0, ceil_eff}) ? ceil_eff : raise_sum[GAIN_W-1:0];
    // saturated at lowest gain, or low with gain already at the ceiling: accept
    go_down      = !unstable && is_high && (gain_r != '0);
    go_up        = !unstable && !is_high && (scan_max < low_thr_r) && (gain_r < ceil_eff);
    gain_change  = go_down || go_up;
  end

  // rounded shift by gain + 7 with saturation to 32 bits
  always_comb begin
    gain_clamp = (gain_r > GAIN_TOP) ? GAIN_TOP : gain_r;
    shamt      = 5'(gain_clamp) + 5'd7;
    rnd_sum    = {1'b0, prod1} + ((PROD1_W+1)'(1) << (shamt - 5'd1));
    rnd_shift  = rnd_sum >> shamt;
    ppfd_sat   = (|rnd_shift[PROD1_W:PPFD_W]) ? '1 : rnd_shift[PPFD_W-1:0];
  end

  // rounded micromole increment into the saturating total
  always_comb begin
    inc_full = {1'b0, prod2} + (PROD2_W+1)'(128);
    tot_sum  = {1'b0, total_r} + (TOTAL_W+1)'(inc_full[PROD2_W:8]);
    tot_sat  = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
  end

  assign scan_start = in_acc && !in_func;
  assign mul1_start = (state_r == ST_DECIDE) && !gain_change;
  assign mul2_start = (state_r == ST_KICK2);
  assign out_free   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      gain_r       <= GAIN_RESET;
      attempts_r   <= '0;
      ppfd_r       <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
      res_action_r <= ACT_ACCEPTED;
      res_max_r    <= '0;
      elapsed_r    <= '0;
      out_action_r <= '0;
      out_gain_r   <= '0;
      out_max_r    <= '0;
      out_ppfd_r   <= '0;
      out_total_r  <= '0;
    end else begin
      // result taken downstream; in the hand-off state the new one replaces it
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_func) begin
              // clear transaction: zero the total, report max as zero
              total_r      <= '0;
              res_action_r <= ACT_CLEARED;
              res_max_r    <= '0;
              state_r      <= ST_DONE;
            end else begin
              elapsed_r <= in_elapsed_seconds;
              state_r   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          res_max_r <= scan_max;
          if (gain_change) begin
            gain_r       <= go_down ? gain_lowered : gain_raised;
            attempts_r   <= attempts_r + ATT_W'(1);
            res_action_r <= ACT_GAIN_CHANGED;
            state_r      <= ST_DONE;
          end else begin
            // accepted as is; after the last attempt it is flagged unstable
            attempts_r   <= '0;
            res_action_r <= unstable ? ACT_UNSTABLE : ACT_ACCEPTED;
            state_r      <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          if (mul1_done) begin
            state_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          ppfd_r  <= ppfd_sat;
          state_r <= ST_KICK2;
        end
        ST_KICK2: begin
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          if (mul2_done) begin
            state_r <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          total_r <= tot_sat;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          // hand the result to the output register once it has room
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_action_r <= res_action_r;
            out_gain_r   <= gain_r;
            out_max_r    <= res_max_r;
            out_ppfd_r   <= ppfd_r;
            out_total_r  <= total_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_action           = out_action_r;
  assign out_gain_index       = out_gain_r;
  assign out_max_count        = out_max_r;
  assign out_ppfd_q8          = out_ppfd_r;
  assign out_daily_total_umol = out_total_r;

  // gain never leaves the legal index range
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= GAIN_TOP)
    else $error("gain index above top");

  // attempts never run past the limit
  a_attempts: assert property (@(posedge clk) disable iff (!rst_n)
    attempts_r <= ATT_W'(MAX_ATTEMPTS))
    else $error("attempt count past limit");

  // the total only falls on a clear transaction
  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(in_valid && !in_stall && in_func)
      |-> total_r >= $past(total_r))
    else $error("daily total decreased without clear");

  // ppfd only moves in the rounding step
  a_ppfd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_ROUND |=> $stable(ppfd_r))
    else $error("ppfd changed outside rounding step");

endmodule
